// File: hdl/owss_pkg.sv
// Package for the 1-Wire slave slot engine: phase encoding, command codes,
// register indexes and fixed protocol timing constants. No dependencies.
`default_nettype none
package owss_pkg;

   typedef enum logic [3:0] {
      PH_IDLE, PH_RST, PH_RD_EDGE, PH_RD_DELAY, PH_RD_HOLD, PH_RD_REL,
      PH_WR_EDGE, PH_WR_ZERO, PH_WR_CHECK, PH_WR_REC, PH_CMP_SAMPLE,
      PH_CMP_HOLD, PH_CMP_REL, PH_SR_DRIVE, PH_SR_GAP, PH_SR_EDGE
   } phase_type;

   typedef enum logic [2:0] {
      ACT_TICK, ACT_RESET, ACT_READ, ACT_LATE_READ, ACT_WRITE, ACT_MATCH,
      ACT_SEARCH, ACT_UNUSED
   } action_type;

   localparam logic [2:0] REG_RD_SAMPLE  = 3'd0;
   localparam logic [2:0] REG_RD_HOLD    = 3'd1;
   localparam logic [2:0] REG_LATE_LEAD  = 3'd2;
   localparam logic [2:0] REG_ZERO_LOW   = 3'd3;
   localparam logic [2:0] REG_ONE_CHECK  = 3'd4;
   localparam logic [2:0] REG_WR_TIMEOUT = 3'd5;
   localparam logic [2:0] REG_RST_MIN    = 3'd6;
   localparam logic [2:0] REG_MATCH_DLY  = 3'd7;

   localparam logic [15:0] SAMPLE_PERIOD = 16'd10;
   localparam logic [5:0]  SAMPLE_LIMIT  = 6'd50;
   localparam logic [15:0] ZERO_RECOVERY = 16'd16;
   localparam logic [15:0] ONE_RECOVERY  = 16'd22;
   localparam logic [15:0] SEARCH_DRIVE  = 16'd17;
   localparam logic [15:0] SEARCH_GAP    = 16'd35;
   localparam logic [15:0] SEARCH_ONE    = 16'd55;
   localparam logic [15:0] HOLD_TIME     = 16'd35;
   localparam logic [15:0] RELEASE_LIMIT = 16'd50;

   typedef struct packed {
      logic [7:0]  rd_sample;
      logic [7:0]  rd_hold;
      logic [7:0]  late_lead;
      logic [7:0]  zero_low;
      logic [7:0]  one_check;
      logic [15:0] wr_timeout;
      logic [5:0]  rst_min;
      logic [7:0]  match_dly;
   } cfg_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy;
      logic       done;
      logic       success;
      logic [7:0] rx_byte;
   } result_type;

endpackage
`default_nettype wire

// File: hdl/owss_regs.sv
// Configuration register file for the 1-Wire slave slot engine.
// Depends on owss_pkg for the register indexes and the cfg_type struct.
`default_nettype none
module owss_regs (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [2:0]       wr_index,
   input  wire logic [15:0]      wr_data,
   output owss_pkg::cfg_type     cfg
);
   owss_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rd_sample  <= 8'd20;
         cfg_ff.rd_hold    <= 8'd15;
         cfg_ff.late_lead  <= 8'd20;
         cfg_ff.zero_low   <= 8'd28;
         cfg_ff.one_check  <= 8'd22;
         cfg_ff.wr_timeout <= 16'd20400;
         cfg_ff.rst_min    <= 6'd10;
         cfg_ff.match_dly  <= 8'd10;
      end else if (wr_en) begin
         case (wr_index)
            owss_pkg::REG_RD_SAMPLE:  cfg_ff.rd_sample  <= wr_data[7:0];
            owss_pkg::REG_RD_HOLD:    cfg_ff.rd_hold    <= wr_data[7:0];
            owss_pkg::REG_LATE_LEAD:  cfg_ff.late_lead  <= wr_data[7:0];
            owss_pkg::REG_ZERO_LOW:   cfg_ff.zero_low   <= wr_data[7:0];
            owss_pkg::REG_ONE_CHECK:  cfg_ff.one_check  <= wr_data[7:0];
            owss_pkg::REG_WR_TIMEOUT: cfg_ff.wr_timeout <= wr_data;
            owss_pkg::REG_RST_MIN:    cfg_ff.rst_min    <= wr_data[5:0];
            owss_pkg::REG_MATCH_DLY:  cfg_ff.match_dly  <= wr_data[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

// File: hdl/owss_core.sv
// Slot state machine of the 1-Wire slave engine: one tick per accepted
// transaction. Depends on owss_pkg for phases, codes, constants and structs.
`default_nettype none
module owss_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [2:0]         action,
   input  wire logic               line_high,
   input  wire logic [7:0]         tx_byte,
   input  wire logic               tx_bit,
   input  wire owss_pkg::cfg_type  cfg,
   output owss_pkg::result_type    res
);
   owss_pkg::phase_type phase_ff, phase_in;
   logic [15:0] timer_ff, timer_in;
   logic [3:0]  bits_ff, bits_in;
   logic [7:0]  rxs_ff, rxs_in, txs_ff, txs_in;
   logic        exp_ff, exp_in;
   logic [5:0]  samp_ff, samp_in;

   logic [15:0] tinc, d;
   logic        reached, sval, sval_next;
   logic [3:0]  bits_p1;
   logic [5:0]  samp_p1;
   logic [7:0]  late_d;

   always_comb begin
      tinc    = timer_ff + 16'd1;
      bits_p1 = bits_ff + 4'd1;
      samp_p1 = samp_ff + 6'd1;
      sval    = (bits_ff == 4'd0) ? exp_ff : ~exp_ff;
      late_d  = (cfg.rd_sample > cfg.late_lead) ? (cfg.rd_sample - cfg.late_lead) : 8'd0;
      case (phase_ff)
         owss_pkg::PH_RST:        d = owss_pkg::SAMPLE_PERIOD;
         owss_pkg::PH_RD_DELAY:   d = {8'd0, (bits_ff == 4'd0 && exp_ff) ? late_d
                                                                          : cfg.rd_sample};
         owss_pkg::PH_RD_HOLD:    d = {8'd0, cfg.rd_hold};
         owss_pkg::PH_WR_EDGE:    d = cfg.wr_timeout;
         owss_pkg::PH_WR_ZERO:    d = {8'd0, cfg.zero_low};
         owss_pkg::PH_WR_CHECK:   d = {8'd0, cfg.one_check};
         owss_pkg::PH_WR_REC:     d = exp_ff ? owss_pkg::ONE_RECOVERY
                                             : owss_pkg::ZERO_RECOVERY;
         owss_pkg::PH_CMP_SAMPLE: d = {8'd0, cfg.match_dly};
         owss_pkg::PH_CMP_HOLD:   d = owss_pkg::HOLD_TIME;
         owss_pkg::PH_CMP_REL:    d = owss_pkg::RELEASE_LIMIT;
         owss_pkg::PH_SR_DRIVE:   d = owss_pkg::SEARCH_DRIVE;
         owss_pkg::PH_SR_GAP:     d = sval ? owss_pkg::SEARCH_ONE : owss_pkg::SEARCH_GAP;
         default:                 d = 16'd0;
      endcase
      reached = tinc >= d;
   end

   // Next state.
   always_comb begin
      phase_in = phase_ff; timer_in = timer_ff; bits_in = bits_ff;
      rxs_in = rxs_ff; txs_in = txs_ff; exp_in = exp_ff; samp_in = samp_ff;
      sval_next = 1'b0;
      case (phase_ff)
         owss_pkg::PH_IDLE: begin
            timer_in = 16'd0;
            bits_in  = 4'd0;
            case (owss_pkg::action_type'(action))
               owss_pkg::ACT_RESET: begin
                  samp_in = 6'd0; phase_in = owss_pkg::PH_RST;
               end
               owss_pkg::ACT_READ: begin
                  rxs_in = 8'd0; exp_in = 1'b0; phase_in = owss_pkg::PH_RD_EDGE;
               end
               owss_pkg::ACT_LATE_READ: begin
                  rxs_in = 8'd0; exp_in = 1'b1; phase_in = owss_pkg::PH_RD_DELAY;
               end
               owss_pkg::ACT_WRITE: begin
                  txs_in = tx_byte; phase_in = owss_pkg::PH_WR_EDGE;
               end
               owss_pkg::ACT_MATCH: begin
                  exp_in = tx_bit; phase_in = owss_pkg::PH_CMP_SAMPLE;
               end
               owss_pkg::ACT_SEARCH: begin
                  exp_in = tx_bit;
                  phase_in = tx_bit ? owss_pkg::PH_SR_GAP : owss_pkg::PH_SR_DRIVE;
               end
               default: ;
            endcase
         end
         owss_pkg::PH_RST: begin
            timer_in = tinc;
            if (reached) begin
               timer_in = 16'd0;
               if (line_high) phase_in = owss_pkg::PH_IDLE;
               else begin
                  samp_in = samp_p1;
                  if (samp_p1 >= owss_pkg::SAMPLE_LIMIT) phase_in = owss_pkg::PH_IDLE;
               end
            end
         end
         owss_pkg::PH_RD_EDGE:
            if (!line_high) begin
               timer_in = 16'd0; phase_in = owss_pkg::PH_RD_DELAY;
            end
         owss_pkg::PH_RD_DELAY: begin
            timer_in = tinc;
            if (reached) begin
               if (line_high) rxs_in = rxs_ff | (8'd1 << bits_ff[2:0]);
               timer_in = 16'd0; phase_in = owss_pkg::PH_RD_HOLD;
            end
         end
         owss_pkg::PH_RD_HOLD, owss_pkg::PH_RD_REL: begin
            if (phase_ff == owss_pkg::PH_RD_HOLD) timer_in = tinc;
            if (phase_ff == owss_pkg::PH_RD_REL || reached) begin
               if (line_high) begin
                  bits_in  = bits_p1;
                  phase_in = (bits_p1 >= 4'd8) ? owss_pkg::PH_IDLE : owss_pkg::PH_RD_EDGE;
               end else phase_in = owss_pkg::PH_RD_REL;
            end
         end
         owss_pkg::PH_WR_EDGE: begin
            if (!line_high) begin
               exp_in = txs_ff[0]; timer_in = 16'd0;
               phase_in = txs_ff[0] ? owss_pkg::PH_WR_CHECK : owss_pkg::PH_WR_ZERO;
            end else if (bits_ff == 4'd0) begin
               timer_in = tinc;
               if (reached) phase_in = owss_pkg::PH_IDLE;
            end
         end
         owss_pkg::PH_WR_ZERO: begin
            timer_in = tinc;
            if (reached) begin
               timer_in = 16'd0; phase_in = owss_pkg::PH_WR_REC;
            end
         end
         owss_pkg::PH_WR_CHECK: begin
            timer_in = tinc;
            if (reached) begin
               timer_in = 16'd0;
               phase_in = line_high ? owss_pkg::PH_WR_REC : owss_pkg::PH_IDLE;
            end
         end
         owss_pkg::PH_WR_REC: begin
            timer_in = tinc;
            if (reached) begin
               txs_in = {1'b0, txs_ff[7:1]}; bits_in = bits_p1;
               phase_in = (bits_p1 >= 4'd8) ? owss_pkg::PH_IDLE : owss_pkg::PH_WR_EDGE;
            end
         end
         owss_pkg::PH_CMP_SAMPLE: begin
            timer_in = tinc;
            if (reached) begin
               timer_in = 16'd0;
               phase_in = (line_high != exp_ff) ? owss_pkg::PH_IDLE : owss_pkg::PH_CMP_HOLD;
            end
         end
         owss_pkg::PH_CMP_HOLD: begin
            timer_in = tinc;
            if (reached) begin
               timer_in = 16'd0;
               phase_in = line_high ? owss_pkg::PH_IDLE : owss_pkg::PH_CMP_REL;
            end
         end
         owss_pkg::PH_CMP_REL: begin
            if (line_high) phase_in = owss_pkg::PH_IDLE;
            else if (bits_ff != 4'd2) begin
               timer_in = tinc;
               if (reached) phase_in = owss_pkg::PH_IDLE;
            end
         end
         owss_pkg::PH_SR_DRIVE: begin
            timer_in = tinc;
            if (reached) begin
               timer_in = 16'd0; phase_in = owss_pkg::PH_SR_GAP;
            end
         end
         owss_pkg::PH_SR_GAP: begin
            timer_in = tinc;
            if (reached) phase_in = owss_pkg::PH_SR_EDGE;
         end
         owss_pkg::PH_SR_EDGE:
            if (!line_high) begin
               timer_in = 16'd0;
               if (bits_p1 == 4'd1) begin
                  bits_in = bits_p1;
                  // Second slot of the triplet carries the complement.
                  sval_next = ~exp_ff;
                  phase_in = sval_next ? owss_pkg::PH_SR_GAP : owss_pkg::PH_SR_DRIVE;
               end else begin
                  bits_in = 4'd2; phase_in = owss_pkg::PH_CMP_SAMPLE;
               end
            end
         default: phase_in = owss_pkg::PH_IDLE;
      endcase
   end

   // Outputs of this tick.
   always_comb begin
      res.drive_low = 1'b0;
      res.done      = 1'b0;
      res.success   = 1'b0;
      res.rx_byte   = 8'd0;
      case (phase_ff)
         owss_pkg::PH_IDLE:
            res.drive_low = (owss_pkg::action_type'(action) == owss_pkg::ACT_SEARCH) && !tx_bit;
         owss_pkg::PH_RST:
            if (phase_in == owss_pkg::PH_IDLE) begin
               res.done = 1'b1;
               res.success = (samp_in >= cfg.rst_min);
            end
         owss_pkg::PH_RD_HOLD, owss_pkg::PH_RD_REL:
            if (phase_in == owss_pkg::PH_IDLE) begin
               res.done = 1'b1; res.rx_byte = rxs_ff;
            end
         owss_pkg::PH_WR_EDGE: begin
            res.drive_low = !line_high && !txs_ff[0];
            res.done = (phase_in == owss_pkg::PH_IDLE);
         end
         owss_pkg::PH_WR_ZERO:   res.drive_low = !reached;
         owss_pkg::PH_SR_DRIVE:  res.drive_low = !reached;
         owss_pkg::PH_WR_CHECK:  res.done = (phase_in == owss_pkg::PH_IDLE);
         owss_pkg::PH_WR_REC:
            if (phase_in == owss_pkg::PH_IDLE) begin
               res.done = 1'b1; res.success = 1'b1;
            end
         owss_pkg::PH_CMP_SAMPLE: res.done = (phase_in == owss_pkg::PH_IDLE);
         owss_pkg::PH_CMP_HOLD, owss_pkg::PH_CMP_REL:
            if (phase_in == owss_pkg::PH_IDLE) begin
               res.done = 1'b1; res.success = line_high;
            end
         owss_pkg::PH_SR_EDGE:
            res.drive_low = !line_high && (bits_p1 == 4'd1) && exp_ff;
         default: ;
      endcase
      res.busy = (phase_in != owss_pkg::PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= owss_pkg::PH_IDLE;
         timer_ff <= 16'd0; bits_ff <= 4'd0; rxs_ff <= 8'd0; txs_ff <= 8'd0;
         exp_ff <= 1'b0; samp_ff <= 6'd0;
      end else if (step) begin
         phase_ff <= phase_in; timer_ff <= timer_in; bits_ff <= bits_in;
         rxs_ff <= rxs_in; txs_ff <= txs_in; exp_ff <= exp_in; samp_ff <= samp_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      res.done |-> !res.busy) else $error("done while still busy");
   assert property (@(posedge clock) disable iff (reset)
      (res.rx_byte != 8'd0) |-> res.done) else $error("rx byte outside done");
   assert property (@(posedge clock) disable iff (reset)
      res.success |-> res.done) else $error("success outside done");
   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff)) else $error("phase moved without a tick");
endmodule
`default_nettype wire

// File: hdl/onewire_slave_slot_engine_unit.sv
// Top level of the 1-Wire slave slot engine: handshakes, result register.
// Depends on owss_pkg, owss_regs and owss_core.
`default_nettype none
// Each request transaction is one one-microsecond tick carrying the sampled
// bus level and, while the engine is idle, a command: reset detect, byte
// read, late-edge byte read, byte write, match-ROM bit or search-ROM triplet.
// Every tick produces exactly one response transaction with the drive level
// for that tick, busy, done, success and the received byte. The slot state
// machine advances by one step per accepted tick, so one transaction is
// taken every clock unless the response stalls; the response sits in an
// output register, and a new tick is accepted whenever that register is
// empty or being emptied in the same cycle. Registers are written through
// the csr_ channel and should only change while idle.
module onewire_slave_slot_engine_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [2:0]  req_action,
   input  wire logic        req_line_high,
   input  wire logic [7:0]  req_tx_byte,
   input  wire logic        req_tx_bit,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_drive_low,
   output      logic        rsp_busy_res,
   output      logic        rsp_done_res,
   output      logic        rsp_success,
   output      logic [7:0]  rsp_rx_byte,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   owss_pkg::cfg_type    cfg;
   owss_pkg::result_type res, res_ff;
   logic                 valid_ff, step;

   assign csr_ready = 1'b1;
   assign req_ready = !valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   owss_regs u_regs (
      .clock(clock), .reset(reset), .wr_en(csr_valid), .wr_index(csr_index),
      .wr_data(csr_data), .cfg(cfg)
   );

   owss_core u_core (
      .clock(clock), .reset(reset), .step(step), .action(req_action),
      .line_high(req_line_high), .tx_byte(req_tx_byte), .tx_bit(req_tx_bit),
      .cfg(cfg), .res(res)
   );

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (req_ready) valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (step) res_ff <= res;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_drive_low = res_ff.drive_low;
   assign rsp_busy_res  = res_ff.busy;
   assign rsp_done_res  = res_ff.done;
   assign rsp_success   = res_ff.success;
   assign rsp_rx_byte   = res_ff.rx_byte;

   assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid) else $error("accepted tick left no response");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(res_ff)) else $error("response changed");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready) else $error("overrun of response");
endmodule
`default_nettype wire
